// ===== src/tps_pkg.sv =====
package tps_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned PROD_W     = COORD_W + DIFF_W;
  localparam int unsigned DIST_SHIFT = 3;
  localparam int unsigned TERM_W     = PROD_W - DIST_SHIFT;
  localparam int unsigned DIST_W     = 64;
  localparam int unsigned DEN_W      = DIST_W + 1;
  localparam int unsigned REM_W      = DEN_W + 1;
  localparam int unsigned T_FRAC     = 30;
  localparam int unsigned Q_W        = T_FRAC + 1;
  localparam int unsigned NDIV       = T_FRAC + 1;
  localparam int unsigned IPROD_W    = DIFF_W + Q_W + 1;
  localparam int unsigned SUM_W      = IPROD_W - T_FRAC + 1;
  localparam int unsigned IDX_W      = 3;

  localparam logic [COORD_W-1:0] NORMAL_Z_RESET = 32'h0001_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_idx_t;

  // index 0 = x, 1 = y, 2 = z
  typedef logic [2:0][COORD_W-1:0] vec_t;
  typedef logic [2:0][DIFF_W-1:0]  dvec_t;

  typedef struct packed {
    vec_t             s;
    dvec_t            d;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] num;
  } edge_t;

  typedef struct packed {
    edge_t first;
    edge_t second;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'(32'sh7FFF_FFFF));
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

// ===== src/tps_tri_if.sv =====
interface tps_tri_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_x, a_y, a_z;
  logic [31:0] b_x, b_y, b_z;
  logic [31:0] c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

// ===== src/tps_seg_if.sv =====
interface tps_seg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_x, start_y, start_z;
  logic [31:0] end_x, end_y, end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

// ===== src/tps_cfg_if.sv =====
interface tps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tps_front.sv =====
module tps_front import tps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  vec_t       plane_point,
  input  vec_t       plane_normal,
  tps_tri_if.sink    triangle,
  input  logic       q_full,
  output logic       push,
  output seg_t       push_seg
);

  logic adv;

  vec_t vin [3];
  logic v1, v2, v3, v4, v5;

  vec_t  vx1 [3];
  dvec_t dif1 [3];
  dvec_t dl1 [3];

  logic [TERM_W-1:0] term2 [3][3];
  vec_t  vx2 [3];
  dvec_t dl2 [3];

  logic [DIST_W-1:0] dist3 [3];
  vec_t  vx3 [3];
  dvec_t dl3 [3];

  logic [DEN_W-1:0] den4 [3];
  logic [DEN_W-1:0] nden4 [3];
  logic [DEN_W-1:0] num4 [3];
  logic [DEN_W-1:0] nnum4 [3];
  logic             allpos4, allneg4;
  vec_t  es4 [3];
  dvec_t ed4 [3];

  logic  hit [3];
  edge_t ecand [3];
  logic  emit;
  seg_t  seg_next;

  assign vin[0] = {triangle.a_z, triangle.a_y, triangle.a_x};
  assign vin[1] = {triangle.b_z, triangle.b_y, triangle.b_x};
  assign vin[2] = {triangle.c_z, triangle.c_y, triangle.c_x};

  assign adv = !v5 || !q_full;
  assign triangle.ready = adv;
  assign push = v5 && !q_full;

  // vertex differences and edge vectors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        vx1[v] <= vin[v];
        for (int i = 0; i < 3; i++) begin
          dif1[v][i] <= DIFF_W'(signed'(vin[v][i])) - DIFF_W'(signed'(plane_point[i]));
        end
      end
      for (int i = 0; i < 3; i++) begin
        dl1[0][i] <= DIFF_W'(signed'(vin[1][i])) - DIFF_W'(signed'(vin[0][i]));
        dl1[1][i] <= DIFF_W'(signed'(vin[2][i])) - DIFF_W'(signed'(vin[0][i]));
        dl1[2][i] <= DIFF_W'(signed'(vin[2][i])) - DIFF_W'(signed'(vin[1][i]));
      end
    end
  end

  // normal products, floor-shifted
  always_ff @(posedge clk) begin
    logic signed [PROD_W-1:0] p;
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < 3; i++) begin
          p = PROD_W'(signed'(plane_normal[i])) * PROD_W'(signed'(dif1[v][i]));
          term2[v][i] <= p[PROD_W-1:DIST_SHIFT];
        end
      end
      vx2 <= vx1;
      dl2 <= dl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        dist3[v] <= DIST_W'(signed'(term2[v][0])) + DIST_W'(signed'(term2[v][1]))
                  + DIST_W'(signed'(term2[v][2]));
      end
      vx3 <= vx2;
      dl3 <= dl2;
    end
  end

  // edge order: AB, AC, BC
  always_ff @(posedge clk) begin
    logic [1:0] si [3];
    logic [1:0] ei [3];
    if (adv) begin
      si[0] = 2'd0; ei[0] = 2'd1;
      si[1] = 2'd0; ei[1] = 2'd2;
      si[2] = 2'd1; ei[2] = 2'd2;
      for (int e = 0; e < 3; e++) begin
        den4[e]  <= DEN_W'(signed'(dist3[ei[e]])) - DEN_W'(signed'(dist3[si[e]]));
        nden4[e] <= DEN_W'(signed'(dist3[si[e]])) - DEN_W'(signed'(dist3[ei[e]]));
        num4[e]  <= -DEN_W'(signed'(dist3[si[e]]));
        nnum4[e] <= DEN_W'(signed'(dist3[si[e]]));
        es4[e]   <= vx3[si[e]];
        ed4[e]   <= dl3[e];
      end
      allpos4 <= !dist3[0][DIST_W-1] && (dist3[0] != '0) &&
                 !dist3[1][DIST_W-1] && (dist3[1] != '0) &&
                 !dist3[2][DIST_W-1] && (dist3[2] != '0);
      allneg4 <= dist3[0][DIST_W-1] && dist3[1][DIST_W-1] && dist3[2][DIST_W-1];
    end
  end

  always_comb begin
    logic [DEN_W-1:0] dn;
    logic [DEN_W-1:0] nm;
    for (int e = 0; e < 3; e++) begin
      dn = den4[e][DEN_W-1] ? nden4[e] : den4[e];
      nm = den4[e][DEN_W-1] ? nnum4[e] : num4[e];
      hit[e] = (dn != '0) && !nm[DEN_W-1] && ($signed(nm) <= $signed(dn));
      ecand[e] = '{s: es4[e], d: ed4[e], den: dn, num: nm};
    end
    emit = v4 && !allpos4 && !allneg4 &&
           ((32'(hit[0]) + 32'(hit[1]) + 32'(hit[2])) == 32'd2);
    seg_next.first  = hit[0] ? ecand[0] : ecand[1];
    seg_next.second = (hit[0] && hit[1]) ? ecand[1] : ecand[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= triangle.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) push_seg <= seg_next;
  end

endmodule

// ===== src/tps_queue.sv =====
module tps_queue import tps_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  seg_t    push_seg,
  input  logic    pop,
  output seg_t    head,
  output q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  seg_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_seg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== src/tps_back.sv =====
module tps_back import tps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  seg_t    head,
  input  q_stat_t stat,
  output logic    pop,
  tps_seg_if.source segment
);

  logic adv;

  logic             dv_valid [NDIV];
  seg_t             dv_seg [NDIV];
  logic [REM_W-1:0] dv_r [NDIV][2];
  logic [Q_W-1:0]   dv_q [NDIV][2];

  logic                     mv_valid;
  vec_t                     ms [2];
  logic [IPROD_W-1:0]       mp [2][3];

  assign adv = !segment.valid || segment.ready;
  assign pop = adv && !stat.empty;

  // first quotient bit: num >= den, which here means num == den
  always_ff @(posedge clk) begin
    edge_t e [2];
    if (adv) begin
      e[0] = head.first;
      e[1] = head.second;
      dv_seg[0] <= head;
      for (int k = 0; k < 2; k++) begin
        if (e[k].num >= e[k].den) begin
          dv_r[0][k] <= REM_W'(e[k].num - e[k].den);
          dv_q[0][k] <= Q_W'(1);
        end else begin
          dv_r[0][k] <= REM_W'(e[k].num);
          dv_q[0][k] <= '0;
        end
      end
    end
  end

  for (genvar g = 1; g < NDIV; g++) begin : g_div
    always_ff @(posedge clk) begin
      logic [REM_W-1:0] r2;
      logic [REM_W-1:0] dd;
      if (adv) begin
        dv_seg[g] <= dv_seg[g-1];
        for (int k = 0; k < 2; k++) begin
          r2 = {dv_r[g-1][k][REM_W-2:0], 1'b0};
          dd = (k == 0) ? REM_W'(dv_seg[g-1].first.den) : REM_W'(dv_seg[g-1].second.den);
          if (r2 >= dd) begin
            dv_r[g][k] <= r2 - dd;
            dv_q[g][k] <= {dv_q[g-1][k][Q_W-2:0], 1'b1};
          end else begin
            dv_r[g][k] <= r2;
            dv_q[g][k] <= {dv_q[g-1][k][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // scale edge vectors by t
  always_ff @(posedge clk) begin
    dvec_t dl [2];
    if (adv) begin
      dl[0] = dv_seg[NDIV-1].first.d;
      dl[1] = dv_seg[NDIV-1].second.d;
      ms[0] <= dv_seg[NDIV-1].first.s;
      ms[1] <= dv_seg[NDIV-1].second.s;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          mp[k][i] <= IPROD_W'(signed'(dl[k][i])) *
                      IPROD_W'(signed'({1'b0, dv_q[NDIV-1][k]}));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] v [2][3];
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          v[k][i] = SUM_W'(signed'(ms[k][i])) + SUM_W'(signed'(mp[k][i][IPROD_W-1:T_FRAC]));
        end
      end
      segment.start_x <= sat32(v[0][0]);
      segment.start_y <= sat32(v[0][1]);
      segment.start_z <= sat32(v[0][2]);
      segment.end_x   <= sat32(v[1][0]);
      segment.end_y   <= sat32(v[1][1]);
      segment.end_z   <= sat32(v[1][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NDIV; g++) dv_valid[g] <= 1'b0;
      mv_valid      <= 1'b0;
      segment.valid <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= !stat.empty;
      for (int g = 1; g < NDIV; g++) dv_valid[g] <= dv_valid[g-1];
      mv_valid      <= dv_valid[NDIV-1];
      segment.valid <= mv_valid;
    end
  end

endmodule

// ===== src/triangle_plane_slicer.sv =====
// channel    dir  beat contents
// cfg        in   index (0..5), data: plane point xyz, plane normal xyz
// triangle   in   a_x..c_z: three vertices, signed Q16.16
// segment    out  start_x..end_z: cut segment, signed Q16.16, saturated
//
// One triangle per cycle while triangle.ready is high.
// Path: 5 front stages, queue, 31 divider stages, multiply, add/saturate.
// Synchronous reset clears valids and loads the plane as z = 0, normal +z.
// A stalled segment port fills the queue; then triangle.ready drops.
module triangle_plane_slicer import tps_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  tps_cfg_if.sink    cfg,
  tps_tri_if.sink    triangle,
  tps_seg_if.source  segment
);

  vec_t    plane_point;
  vec_t    plane_normal;
  logic    push;
  seg_t    push_seg;
  logic    pop;
  seg_t    head;
  q_stat_t stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_point  <= '0;
      plane_normal <= {NORMAL_Z_RESET, 32'd0, 32'd0};
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_POINT_X:  plane_point[0]  <= cfg.data;
        REG_POINT_Y:  plane_point[1]  <= cfg.data;
        REG_POINT_Z:  plane_point[2]  <= cfg.data;
        REG_NORMAL_X: plane_normal[0] <= cfg.data;
        REG_NORMAL_Y: plane_normal[1] <= cfg.data;
        REG_NORMAL_Z: plane_normal[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  tps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .plane_point  (plane_point),
    .plane_normal (plane_normal),
    .triangle     (triangle),
    .q_full       (stat.full),
    .push         (push),
    .push_seg     (push_seg)
  );

  tps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_seg (push_seg),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  tps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .stat    (stat),
    .pop     (pop),
    .segment (segment)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("queue popped while empty");

  a_stall_means_backlog: assert property (@(posedge clk) disable iff (rst)
    !triangle.ready |-> stat.full)
    else $error("triangle stalled with room in queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    stat.full && !pop |=> !stat.empty)
    else $error("full queue drained without pop");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !segment.valid)
    else $error("segment valid right after reset");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tps_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } facet_t;

  typedef struct packed {
    vec_t seg_start;
    vec_t seg_end;
  } cut_t;

  class slice_board;
    vec_t   plane_pt;
    vec_t   plane_nrm;
    cut_t   pending_cuts[$];
    int     n_mismatch;
    int     n_fail;

    function void reset_plane();
      plane_pt  = '0;
      plane_nrm = '0;
      plane_nrm[2] = NORMAL_Z_RESET;
      pending_cuts.delete();
      n_mismatch = 0;
      n_fail = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      case (idx)
        REG_POINT_X:  plane_pt[0]  = val;
        REG_POINT_Y:  plane_pt[1]  = val;
        REG_POINT_Z:  plane_pt[2]  = val;
        REG_NORMAL_X: plane_nrm[0] = val;
        REG_NORMAL_Y: plane_nrm[1] = val;
        REG_NORMAL_Z: plane_nrm[2] = val;
        default: ;
      endcase
    endfunction

    function wide_t signed_dist(vec_t v);
      wide_t acc;
      wide_t diff;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        diff = wide_t'(signed'(v[i])) - wide_t'(signed'(plane_pt[i]));
        acc += (wide_t'(signed'(plane_nrm[i])) * diff) >>> DIST_SHIFT;
      end
      return acc;
    endfunction

    function logic [COORD_W-1:0] clamp32(wide_t x);
      if (x > wide_t'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
      if (x < -wide_t'(64'sh8000_0000)) return 32'h8000_0000;
      return x[COORD_W-1:0];
    endfunction

    function bit edge_cross(vec_t s, vec_t e, wide_t ds, wide_t de, output vec_t pt);
      wide_t den;
      wide_t num;
      wide_t q;
      wide_t span;
      pt = '0;
      den = de - ds;
      num = -ds;
      if (den == 0) return 0;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num < 0 || num > den) return 0;
      q = (num <<< T_FRAC) / den;
      for (int i = 0; i < 3; i++) begin
        span = wide_t'(signed'(e[i])) - wide_t'(signed'(s[i]));
        pt[i] = clamp32(wide_t'(signed'(s[i])) + ((span * q) >>> T_FRAC));
      end
      return 1;
    endfunction

    function void note_facet(facet_t f);
      wide_t da, db, dc;
      vec_t  p_ab, p_ac, p_bc;
      bit    h_ab, h_ac, h_bc;
      cut_t  cut;
      da = signed_dist(f.a);
      db = signed_dist(f.b);
      dc = signed_dist(f.c);
      if ((da > 0 && db > 0 && dc > 0) || (da < 0 && db < 0 && dc < 0)) return;
      h_ab = edge_cross(f.a, f.b, da, db, p_ab);
      h_ac = edge_cross(f.a, f.c, da, dc, p_ac);
      h_bc = edge_cross(f.b, f.c, db, dc, p_bc);
      if (int'(h_ab) + int'(h_ac) + int'(h_bc) != 2) return;
      if (h_ab) begin
        cut.seg_start = p_ab;
        cut.seg_end   = h_ac ? p_ac : p_bc;
      end else begin
        cut.seg_start = p_ac;
        cut.seg_end   = p_bc;
      end
      pending_cuts.insert(pending_cuts.size(), cut);
    endfunction

    function void check_cut(cut_t got);
      cut_t want;
      if (pending_cuts.size() == 0) begin
        n_fail++;
        if (n_mismatch++ < 10) $display("unexpected segment %h", got);
        return;
      end
      want = pending_cuts.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.seg_start[i] !== want.seg_start[i] || got.seg_end[i] !== want.seg_end[i]) begin
          n_fail++;
          if (n_mismatch++ < 10)
            $display("segment axis %0d: exp start %h end %h, got start %h end %h", i,
                     want.seg_start[i], want.seg_end[i], got.seg_start[i], got.seg_end[i]);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  slice_board board;
  int sent_count;

  tps_cfg_if cfg_if ();
  tps_tri_if facet_if ();
  tps_seg_if seg_if ();

  triangle_plane_slicer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .triangle (facet_if),
    .segment  (seg_if)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one long open stretch
  initial begin
    int cyc;
    int hold_left;
    bit hold_done;
    cyc = 0;
    hold_left = 0;
    hold_done = 0;
    seg_if.ready = 0;
    forever begin
      @(posedge clk);
      cyc++;
      // start the hold-off while the sender is busy streaming
      if (!hold_done && sent_count >= 1600) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        seg_if.ready <= 1'b0;
        hold_left--;
      end
      else if (cyc >= 1000 && cyc < 2000) seg_if.ready <= 1'b1;
      else seg_if.ready <= ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (!rst && seg_if.valid && seg_if.ready)
      board.check_cut({seg_if.start_z, seg_if.start_y, seg_if.start_x,
                       seg_if.end_z, seg_if.end_y, seg_if.end_x});
  end

  // cfg.valid stays high across back-to-back writes; caller drops it
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic load_plane(vec_t pt, vec_t nrm);
    write_reg(REG_POINT_X, pt[0]);
    write_reg(REG_POINT_Y, pt[1]);
    write_reg(REG_POINT_Z, pt[2]);
    write_reg(REG_NORMAL_X, nrm[0]);
    write_reg(REG_NORMAL_Y, nrm[1]);
    write_reg(REG_NORMAL_Z, nrm[2]);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_facet(facet_t f);
    bit may_idle;
    may_idle = !(sent_count >= 800 && sent_count < 1100);
    if (may_idle && $urandom_range(99) < 19) begin
      facet_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    facet_if.valid <= 1'b1;
    {facet_if.c_z, facet_if.c_y, facet_if.c_x,
     facet_if.b_z, facet_if.b_y, facet_if.b_x,
     facet_if.a_z, facet_if.a_y, facet_if.a_x} <= {f.c, f.b, f.a};
    @(posedge clk);
    while (!facet_if.ready) @(posedge clk);
    board.note_facet(f);
    sent_count++;
  endtask

  // drop valid and let the pipeline empty before touching the plane
  task automatic drain();
    facet_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_cuts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic facet_t unit_facet(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
    facet_t f;
    f.a = {32'(az <<< 16), 32'(ay <<< 16), 32'(ax <<< 16)};
    f.b = {32'(bz <<< 16), 32'(by <<< 16), 32'(bx <<< 16)};
    f.c = {32'(cz <<< 16), 32'(cy <<< 16), 32'(cx <<< 16)};
    return f;
  endfunction

  function automatic logic [31:0] pick_coord(logic [31:0] center);
    case ($urandom_range(9))
      6, 7: return $urandom;
      8: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      9: return center;
      default: return center + $urandom_range(0, 20 * 65536) - 10 * 65536;
    endcase
  endfunction

  function automatic facet_t rand_facet(vec_t center);
    facet_t f;
    for (int i = 0; i < 3; i++) begin
      f.a[i] = pick_coord(center[i]);
      f.b[i] = pick_coord(center[i]);
      f.c[i] = pick_coord(center[i]);
    end
    return f;
  endfunction

  function automatic vec_t rand_small_vec();
    vec_t v;
    for (int i = 0; i < 3; i++) v[i] = $urandom_range(0, 4 * 65536) - 2 * 65536;
    return v;
  endfunction

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) send_facet(rand_facet(board.plane_pt));
    drain();
  endtask

  initial begin
    vec_t pt;
    vec_t nrm;
    facet_t f;
    board = new();
    board.reset_plane();
    sent_count = 0;
    rst = 1;
    cfg_if.valid = 0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    facet_if.valid = 0;
    {facet_if.a_x, facet_if.a_y, facet_if.a_z, facet_if.b_x, facet_if.b_y,
     facet_if.b_z, facet_if.c_x, facet_if.c_y, facet_if.c_z} = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset plane z = 0, normal +z
    send_facet(unit_facet(0, 0, -1, 4, 0, 1, 0, 4, 1));
    send_facet(unit_facet(0, 0, 1, 4, 0, -1, 0, 4, 1));
    send_facet(unit_facet(0, 0, 1, 4, 0, 1, 0, 4, -3));
    send_facet(unit_facet(0, 0, 1, 4, 0, 2, 0, 4, 3));
    send_facet(unit_facet(0, 0, -1, 4, 0, -2, 0, 4, -3));
    send_facet(unit_facet(0, 0, 0, 4, 0, 1, 0, 4, 2));
    send_facet(unit_facet(0, 0, 0, 4, 0, 1, 0, 4, -2));
    send_facet(unit_facet(0, 0, 0, 4, 0, 0, 0, 4, 2));
    send_facet(unit_facet(0, 0, 0, 4, 0, 0, 0, 4, 0));
    send_facet(unit_facet(1, 1, 2, 3, 3, 2, 5, 0, -2));
    f.a = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    f.b = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    f.c = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_facet(f);
    f.a = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    f.b = {32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
    f.c = {32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    send_facet(f);
    f.a = {32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000};
    f.b = {32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    f.c = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    send_facet(f);
    drain();
    run_random(300);

    pt  = rand_small_vec();
    nrm = rand_small_vec();
    load_plane(pt, nrm);
    run_random(300);

    pt  = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    nrm = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    load_plane(pt, nrm);
    run_random(250);

    pt  = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    nrm = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_plane(pt, nrm);
    run_random(250);

    // zero normal: nothing may come out
    load_plane(rand_small_vec(), '0);
    run_random(100);

    pt  = {$urandom, $urandom, $urandom};
    nrm = {$urandom, $urandom, $urandom};
    load_plane(pt, nrm);
    run_random(300);

    // out-of-range indexes must leave the plane alone
    pt  = rand_small_vec();
    nrm = rand_small_vec();
    load_plane(pt, nrm);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    run_random(500);

    if (board.n_fail == 0 && board.pending_cuts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
